// File: rtl/core/cbpe_pkg.sv
package cbpe_pkg;

  // Fixed-point format of the curve parameter and of the products.
  localparam int FRAC_BITS = 16;

  localparam int COORD_W = 32;
  localparam int T_W     = 17;
  localparam int NPTS    = 4;
  localparam int PIDX_W  = 2;
  localparam int NAXES   = 3;
  localparam int COEF_W  = 36;

  // Only the low FRAC_BITS+1 bits of t take part, so t stays below 2.0.
  localparam int TE_W  = (FRAC_BITS + 1 < T_W) ? FRAC_BITS + 1 : T_W;
  localparam int TT_W  = 2 * TE_W - FRAC_BITS;
  localparam int TTT_W = TT_W + TE_W - FRAC_BITS;
  localparam int POW_W = (TTT_W > TT_W) ? ((TTT_W > TE_W) ? TTT_W : TE_W)
                                        : ((TT_W > TE_W) ? TT_W : TE_W);

  // Coefficient times power of t, the shifted term, and the running sum.
  localparam int PROD_W = COEF_W + POW_W + 1;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int ACC_W  = SH_W + 2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

  // Controls that the sequencer sends to every axis lane.
  typedef struct packed {
    logic              wr_pt;
    logic [PIDX_W-1:0] pidx;
    logic              rebuild;
    logic              step_c;
    logic              step_b;
    logic              step_a;
  } lane_ctl_t;

  // Controls for the shared powers-of-t unit.
  typedef struct packed {
    logic ld_t;
    logic do_tt;
    logic do_ttt;
  } pow_ctl_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/cbpe_in_if.sv
interface cbpe_in_if import cbpe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [PIDX_W-1:0]         point_index;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] pz;
  logic [T_W-1:0]            t_param;

  modport source (
    output valid, op, point_index, px, py, pz, t_param,
    input  ready
  );

  modport sink (
    input  valid, op, point_index, px, py, pz, t_param,
    output ready
  );
endinterface

// File: rtl/core/cbpe_out_if.sv
interface cbpe_out_if import cbpe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;

  modport source (
    output valid, out_x, out_y, out_z,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z,
    output ready
  );
endinterface

// File: rtl/core/cbpe_tpow.sv
module cbpe_tpow import cbpe_pkg::*; (
  input  logic             clk,
  input  pow_ctl_t         ctl,
  input  logic [T_W-1:0]   t_in,
  output logic [TE_W-1:0]  t,
  output logic [TT_W-1:0]  tt,
  output logic [TTT_W-1:0] ttt
);

  logic [2*TE_W-1:0]       sq;
  logic [TT_W+TE_W-1:0]    cube;

  assign sq   = (2 * TE_W)'(t) * (2 * TE_W)'(t);
  assign cube = (TT_W + TE_W)'(tt) * (TT_W + TE_W)'(t);

  always_ff @(posedge clk) begin
    if (ctl.ld_t) begin
      t <= t_in[TE_W-1:0];
    end
    if (ctl.do_tt) begin
      tt <= sq[FRAC_BITS +: TT_W];
    end
    if (ctl.do_ttt) begin
      ttt <= cube[FRAC_BITS +: TTT_W];
    end
  end

endmodule

// File: rtl/core/cbpe_lane.sv
module cbpe_lane import cbpe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  lane_ctl_t                 ctl,
  input  logic signed [COORD_W-1:0] p_in,
  input  logic [TE_W-1:0]           t,
  input  logic [TT_W-1:0]           tt,
  input  logic [TTT_W-1:0]          ttt,
  output logic signed [ACC_W-1:0]   sum
);

  logic signed [COORD_W-1:0] pts [NPTS];
  logic signed [COEF_W-1:0]  coef_d, coef_c, coef_b, coef_a;
  logic signed [COEF_W-1:0]  e0, e1, e2, e3, d1, d2;
  logic signed [COEF_W-1:0]  c_next, b_next, a_next;
  logic signed [COEF_W-1:0]  m_coef;
  logic [POW_W-1:0]          m_pow;
  logic signed [PROD_W-1:0]  prod, prod_next;
  logic signed [SH_W-1:0]    sh;
  logic signed [ACC_W-1:0]   sh_ext, acc;

  // Power-basis coefficients from the four control points of this axis.
  assign e0     = COEF_W'(pts[0]);
  assign e1     = COEF_W'(pts[1]);
  assign e2     = COEF_W'(pts[2]);
  assign e3     = COEF_W'(pts[3]);
  assign d1     = e1 - e0;
  assign d2     = e2 - e1;
  assign c_next = d1 + (d1 <<< 1);
  assign b_next = d2 + (d2 <<< 1) - c_next;
  assign a_next = e3 - e0 - c_next - b_next;

  // One multiplier per lane, used for c*t, then b*t^2, then a*t^3.
  always_comb begin
    m_coef = '0;
    m_pow  = '0;
    if (ctl.step_c) begin
      m_coef = coef_c;
      m_pow  = POW_W'(t);
    end else if (ctl.step_b) begin
      m_coef = coef_b;
      m_pow  = POW_W'(tt);
    end else if (ctl.step_a) begin
      m_coef = coef_a;
      m_pow  = POW_W'(ttt);
    end
  end

  assign prod_next = PROD_W'(m_coef) * PROD_W'($signed({1'b0, m_pow}));
  assign sh        = SH_W'(prod >>> FRAC_BITS);
  assign sh_ext    = ACC_W'(sh);
  assign sum       = acc + sh_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NPTS; i++) begin
        pts[i] <= '0;
      end
      coef_d <= '0;
      coef_c <= '0;
      coef_b <= '0;
      coef_a <= '0;
    end else begin
      if (ctl.wr_pt) begin
        pts[ctl.pidx] <= p_in;
      end
      if (ctl.rebuild) begin
        coef_d <= e0;
        coef_c <= c_next;
        coef_b <= b_next;
        coef_a <= a_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step_c || ctl.step_b || ctl.step_a) begin
      prod <= prod_next;
    end
    if (ctl.step_b) begin
      acc <= ACC_W'(coef_d) + sh_ext;
    end else if (ctl.step_a) begin
      acc <= acc + sh_ext;
    end
  end

endmodule

// File: rtl/core/cubic_bezier_point_eval.sv
// A sample passes S_TT, S_TTT and S_A and lands in the result register in S_SUM,
// which waits while that register is full; a load passes S_COEF. Items are taken
// one at a time; each axis lane's single multiplier is used three times in a row per sample.
// The result register lets the next item in while a result waits.
// Reset (rst, synchronous, active high) clears all control points and
// coefficients to zero, empties the result register and idles the sequencer.
module cubic_bezier_point_eval import cbpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cbpe_in_if.sink    in_ch,
  cbpe_out_if.source out_ch
);

  // The sequencer walks one item at a time. A load writes its point at the
  // input transfer and rebuilds the coefficients in S_COEF. A sample stores
  // t at the transfer, then forms t^2 and t^3 in the shared power unit while
  // the lanes accumulate c*t, b*t^2 and a*t^3 on top of d.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_COEF = 6'b000010,
    S_TT   = 6'b000100,
    S_TTT  = 6'b001000,
    S_A    = 6'b010000,
    S_SUM  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic       in_fire;
  logic       cap;
  lane_ctl_t  lane_ctl;
  pow_ctl_t   pow_ctl;

  logic [TE_W-1:0]           t;
  logic [TT_W-1:0]           tt;
  logic [TTT_W-1:0]          ttt;
  logic signed [COORD_W-1:0] p_in [NAXES];
  logic signed [ACC_W-1:0]   sums [NAXES];
  logic signed [COORD_W-1:0] res  [NAXES];
  logic                      out_valid;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // The final add lands in the result register only once it is free or
  // being emptied in this same cycle.
  assign cap = (state == S_SUM) && (!out_valid || out_ch.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (in_ch.op == OP_LOAD) ? S_COEF : S_TT;
        end
      end
      S_COEF:  state_next = S_IDLE;
      S_TT:    state_next = S_TTT;
      S_TTT:   state_next = S_A;
      S_A:     state_next = S_SUM;
      S_SUM: begin
        if (cap) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    lane_ctl.wr_pt   = in_fire && (in_ch.op == OP_LOAD);
    lane_ctl.pidx    = in_ch.point_index;
    lane_ctl.rebuild = (state == S_COEF);
    lane_ctl.step_c  = (state == S_TT);
    lane_ctl.step_b  = (state == S_TTT);
    lane_ctl.step_a  = (state == S_A);
    pow_ctl.ld_t     = in_fire && (in_ch.op == OP_SAMPLE);
    pow_ctl.do_tt    = (state == S_TT);
    pow_ctl.do_ttt   = (state == S_TTT);
  end

  cbpe_tpow u_tpow (
    .clk  (clk),
    .ctl  (pow_ctl),
    .t_in (in_ch.t_param),
    .t    (t),
    .tt   (tt),
    .ttt  (ttt)
  );

  assign p_in[0] = in_ch.px;
  assign p_in[1] = in_ch.py;
  assign p_in[2] = in_ch.pz;

  // One lane per axis; all lanes run in lockstep on the same controls.
  for (genvar ax = 0; ax < NAXES; ax++) begin : g_lane
    cbpe_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (lane_ctl),
      .p_in (p_in[ax]),
      .t    (t),
      .tt   (tt),
      .ttt  (ttt),
      .sum  (sums[ax])
    );
  end

  // Merge stage: saturate each lane's sum and register the three axes
  // together as one result.
  always_ff @(posedge clk) begin
    if (cap) begin
      for (int i = 0; i < NAXES; i++) begin
        res[i] <= sat_coord(sums[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cap || (out_valid && !out_ch.ready);
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.out_x = res[0];
  assign out_ch.out_y = res[1];
  assign out_ch.out_z = res[2];

endmodule

// File: rtl/core/cbpe_checker.sv
module cbpe_checker import cbpe_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_op,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COORD_W-1:0] out_x,
  input logic signed [COORD_W-1:0] out_y,
  input logic signed [COORD_W-1:0] out_z
);

  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  // A waiting result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A waiting result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("result changed while stalled");

  // Items are worked one at a time, so no transfer follows right away.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("input taken while busy");

  // With the result register empty, a sample's result comes out without waiting in S_SUM.
  a_sample_latency: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (in_op == OP_SAMPLE) && !out_valid |-> ##5 out_valid)
    else $error("sample result late or missing");

  // A load never raises a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (in_op == OP_LOAD) |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("load produced a result");

endmodule

bind cubic_bezier_point_eval cbpe_checker u_cbpe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y),
  .out_z     (out_ch.out_z)
);
